// ===== src/madt_pkg.sv =====
// Shared types and constants for the MADT APIC id collector.
// No dependencies; used by madt_parse, madt_list and the top level.
`timescale 1ns / 1ps
`default_nettype none

package madt_pkg;

	// Input command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_BOOT_ID  = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	localparam logic [4:0] CAP_RESET = 5'd16;

	// Record layout
	localparam logic [7:0] REC_LAPIC      = 8'd0;
	localparam logic [7:0] REC_X2APIC     = 8'd9;
	localparam logic [7:0] LAPIC_MIN_LEN  = 8'd8;
	localparam logic [7:0] X2APIC_MIN_LEN = 8'd16;
	localparam logic [7:0] REC_MIN_LEN    = 8'd2;
	localparam logic [7:0] LAPIC_ID_POS   = 8'd3;
	localparam logic [7:0] LAPIC_FLG_POS  = 8'd4;
	localparam logic [7:0] X2APIC_ID_POS  = 8'd4;
	localparam logic [7:0] X2APIC_HI_LAST = 8'd7;
	localparam logic [7:0] X2APIC_FLG_POS = 8'd8;

	// Decoded command strobes, one transfer each
	typedef struct packed {
		logic start;
		logic take;
		logic stop;
	} madt_cmd_t;

	// Completed, eligible record
	typedef struct packed {
		logic       hit;
		logic [7:0] id;
	} madt_cand_t;

endpackage

`default_nettype wire

// ===== src/madt_parse.sv =====
// Record parser: walks type/length/body of each record and flags eligible ids.
// Depends on madt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module madt_parse (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire madt_pkg::madt_cmd_t cmd_i,
	input  wire  [7:0]          data_byte,
	output madt_pkg::madt_cand_t cand_o
);

	logic [7:0] pos_q, pos_d;
	logic [7:0] type_q, type_d;
	logic [7:0] len_q, len_d;
	logic [7:0] cand_q, cand_d;
	logic       hi_q, hi_d;
	logic [1:0] en_q, en_d;
	logic       stop_q, stop_d;
	logic       proceed;
	logic       fin;
	logic       ok;

	always_comb begin
		pos_d   = pos_q;
		type_d  = type_q;
		len_d   = len_q;
		cand_d  = cand_q;
		hi_d    = hi_q;
		en_d    = en_q;
		stop_d  = stop_q;
		proceed = 1'b0;
		fin     = 1'b0;
		if (cmd_i.start) begin
			pos_d  = '0;
			type_d = '0;
			len_d  = '0;
			cand_d = '0;
			hi_d   = 1'b0;
			en_d   = '0;
			stop_d = 1'b0;
		end else if (cmd_i.stop) begin
			stop_d = 1'b1;
		end else if (cmd_i.take && !stop_q) begin
			if (pos_q == 8'd0) begin
				type_d = data_byte;
				cand_d = '0;
				hi_d   = 1'b0;
				en_d   = '0;
				pos_d  = 8'd1;
			end else begin
				proceed = 1'b1;
				if (pos_q == 8'd1) begin
					len_d = data_byte;
					if (data_byte < madt_pkg::REC_MIN_LEN) begin
						stop_d  = 1'b1;
						proceed = 1'b0;
					end
				end else if (type_q == madt_pkg::REC_LAPIC) begin
					if (pos_q == madt_pkg::LAPIC_ID_POS)
						cand_d = data_byte;
					else if (pos_q == madt_pkg::LAPIC_FLG_POS)
						en_d = data_byte[1:0];
				end else if (type_q == madt_pkg::REC_X2APIC) begin
					if (pos_q == madt_pkg::X2APIC_ID_POS)
						cand_d = data_byte;
					else if (pos_q > madt_pkg::X2APIC_ID_POS &&
							pos_q <= madt_pkg::X2APIC_HI_LAST) begin
						if (data_byte != 8'd0)
							hi_d = 1'b1;
					end else if (pos_q == madt_pkg::X2APIC_FLG_POS)
						en_d = data_byte[1:0];
				end
				if (proceed) begin
					if ({1'b0, pos_q} + 9'd1 >= {1'b0, len_d}) begin
						fin   = 1'b1;
						pos_d = '0;
					end else begin
						pos_d = pos_q + 8'd1;
					end
				end
			end
		end
	end

	// x2APIC ids above 255 are dropped via the high-byte flag
	assign ok = (type_d == madt_pkg::REC_LAPIC && len_d >= madt_pkg::LAPIC_MIN_LEN) ||
		(type_d == madt_pkg::REC_X2APIC && len_d >= madt_pkg::X2APIC_MIN_LEN && !hi_d);

	assign cand_o.hit = fin && ok && (en_d != 2'b00);
	assign cand_o.id  = cand_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			type_q <= '0;
			len_q  <= '0;
			cand_q <= '0;
			hi_q   <= 1'b0;
			en_q   <= '0;
			stop_q <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			type_q <= type_d;
			len_q  <= len_d;
			cand_q <= cand_d;
			hi_q   <= hi_d;
			en_q   <= en_d;
			stop_q <= stop_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/madt_list.sv =====
// Id list store with a shared compare unit for the duplicate search,
// plus the sequencer that plays the list out. Depends on madt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module madt_list #(
	parameter int unsigned MAX_IDS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire madt_pkg::madt_cmd_t  cmd_i,
	input  wire madt_pkg::madt_cand_t cand_i,
	input  wire  [7:0]           boot_cfg,
	input  wire  [4:0]           cap_cfg,
	output logic                 idle,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           apic_id,
	output logic [4:0]           id_count,
	output logic                 boot_found,
	output logic                 last_id
);

	localparam int unsigned CNTW = $clog2(MAX_IDS + 1);
	localparam int unsigned IDXW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam logic [7:0]  MAX8 = 8'(MAX_IDS);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SEARCH  = 2'd1;
	localparam logic [1:0] ST_EMIT_RD = 2'd2;
	localparam logic [1:0] ST_EMIT_LD = 2'd3;

	logic [1:0]      state_q;
	logic [7:0]      boot_q;
	logic [CNTW-1:0] count_q;
	logic            seen_q;
	logic [7:0]      cand_id_q;
	logic [CNTW-1:0] scan_q;
	logic            chk_q;
	logic [CNTW-1:0] emit_k_q;

	logic [7:0]      mem_q [MAX_IDS];
	logic [7:0]      rdata_q;
	logic [IDXW-1:0] raddr;
	logic            we;

	logic [7:0] cap8;
	logic [7:0] cap_now;
	logic       room;
	logic       issue;
	logic       match;
	logic       load;
	logic       none_case;
	logic       emit_last;

	assign cap8    = {3'b000, cap_cfg};
	assign cap_now = (cap8 > MAX8) ? MAX8 : cap8;
	assign room    = 8'(count_q) < cap_now;

	// Search pipeline: an address is issued, and its read data is compared in the next cycle
	assign issue = scan_q < count_q;
	assign match = chk_q && (rdata_q == cand_id_q);
	assign we    = (state_q == ST_SEARCH) && !match && !issue;
	assign raddr = (state_q == ST_SEARCH) ? scan_q[IDXW-1:0] : emit_k_q[IDXW-1:0];

	assign none_case = !seen_q || (cap_now == 8'd0);
	assign emit_last = none_case || (emit_k_q + CNTW'(1) == count_q);
	assign load      = (state_q == ST_EMIT_LD) && (!out_valid || out_ready);

	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (we)
			mem_q[count_q[IDXW-1:0]] <= cand_id_q;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			boot_q   <= '0;
			count_q  <= CNTW'(1);
			seen_q   <= 1'b0;
			scan_q   <= '0;
			chk_q    <= 1'b0;
			emit_k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_i.start) begin
						boot_q  <= boot_cfg;
						count_q <= CNTW'(1);
						seen_q  <= 1'b0;
					end else if (cmd_i.stop) begin
						emit_k_q <= '0;
						state_q  <= ST_EMIT_RD;
					end else if (cand_i.hit) begin
						if (cand_i.id == boot_q) begin
							seen_q <= 1'b1;
						end else if (room) begin
							scan_q  <= CNTW'(1);
							chk_q   <= 1'b0;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (match) begin
						state_q <= ST_IDLE;
					end else if (!issue) begin
						count_q <= count_q + CNTW'(1);
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + CNTW'(1);
						chk_q  <= 1'b1;
					end
				end
				ST_EMIT_RD: state_q <= ST_EMIT_LD;
				ST_EMIT_LD: begin
					if (load) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_k_q <= emit_k_q + CNTW'(1);
							state_q  <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cand_i.hit)
			cand_id_q <= cand_i.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (none_case) begin
				apic_id    <= '0;
				id_count   <= '0;
				boot_found <= seen_q;
			end else begin
				apic_id    <= (emit_k_q == '0) ? boot_q : rdata_q;
				id_count   <= 5'(count_q);
				boot_found <= 1'b1;
			end
			last_id <= emit_last;
		end
	end

	// Records only arrive while the sequencer is free
	a_hit_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cand_i.hit |-> state_q == ST_IDLE)
		else $error("record completed while list busy");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && 8'(count_q) <= MAX8)
		else $error("list count out of range");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> scan_q <= count_q)
		else $error("search ran past list end");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !cmd_i.start) |=> count_q == $past(count_q))
		else $error("list count moved outside search");

endmodule

`default_nettype wire

// ===== src/madt_apic_id_collector_unit.sv =====
// A record adding a new id adds a search, through the single compare unit,
// over the ids listed so far. End of table: each result goes through a list
// memory read, then a load, and the load waits while a result is unread.
// Not ready while searching or playing out; a waiting result does not block.
// Reset behaves as a start: empty list holding boot id 0, capacity 16.
// Top level: config registers, command decode, parser and id list.
`timescale 1ns / 1ps
`default_nettype none

module madt_apic_id_collector_unit #(
	parameter int unsigned MAX_IDS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [0:0] cfg_index,
	input  wire  [7:0] cfg_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] cmd,
	input  wire  [7:0] data_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] apic_id,
	output logic [4:0] id_count,
	output logic       boot_found,
	output logic       last_id
);

	logic [7:0]           boot_cfg_q;
	logic [4:0]           cap_cfg_q;
	logic                 list_idle;
	logic                 in_xfer;
	madt_pkg::madt_cmd_t  cmd_s;
	madt_pkg::madt_cand_t cand;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_cfg_q <= '0;
			cap_cfg_q  <= madt_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index[0])
				madt_pkg::CFG_BOOT_ID:  boot_cfg_q <= cfg_data;
				madt_pkg::CFG_CAPACITY: cap_cfg_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_ready    = list_idle;
	assign in_xfer     = in_valid && in_ready;
	assign cmd_s.start = in_xfer && (cmd == madt_pkg::CMD_START);
	assign cmd_s.take  = in_xfer && (cmd == madt_pkg::CMD_BYTE);
	assign cmd_s.stop  = in_xfer && (cmd == madt_pkg::CMD_END);

	madt_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_i     (cmd_s),
		.data_byte (data_byte),
		.cand_o    (cand)
	);

	madt_list #(
		.MAX_IDS (MAX_IDS)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_i      (cmd_s),
		.cand_i     (cand),
		.boot_cfg   (boot_cfg_q),
		.cap_cfg    (cap_cfg_q),
		.idle       (list_idle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.apic_id    (apic_id),
		.id_count   (id_count),
		.boot_found (boot_found),
		.last_id    (last_id)
	);

endmodule

`default_nettype wire
